FILE: rtl/ptts_pkg.sv
`default_nettype none
package ptts_pkg;

  localparam int CTR_W        = 15;
  localparam int ID_W         = 8;
  localparam int CAP_W        = 5;
  localparam int NFIRE_W      = 5;
  localparam int RESULT_LIMIT = 16;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_START   = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic             REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0] CAP_RESET    = 5'd16;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CTR_W-1:0] ivl;
  } entry_t;

  typedef struct packed {
    logic             last;
    logic             empty;
    logic             nonempty;
    logic             status;
    logic [CTR_W-1:0] ivl;
    logic [ID_W-1:0]  id;
    logic             fired;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [CTR_W-1:0] dividend;
    logic [CTR_W-1:0] divisor;
  } div_req_t;

endpackage
`default_nettype wire

FILE: rtl/ptts_div.sv
`default_nettype none
module ptts_div
  import ptts_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire div_req_t         req,
  output logic                  done,
  output logic [CTR_W-1:0]      rem
);

  logic [CTR_W-1:0] rem_r, rem_nxt;
  logic [CTR_W-1:0] dvd_r, dvd_nxt;
  logic [CTR_W-1:0] dsr_r, dsr_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CTR_W:0]   trial;

  // Restoring remainder, one dividend bit per cycle.
  assign trial = {rem_r, dvd_r[CTR_W-1]};

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      cnt_nxt  = 4'(CTR_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so it always fits in CTR_W bits.
      rem_nxt = (trial >= {1'b0, dsr_r}) ? CTR_W'(trial - {1'b0, dsr_r})
                                         : trial[CTR_W-1:0];
      dvd_nxt = {dvd_r[CTR_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

FILE: rtl/ptts_table.sv
`default_nettype none
module ptts_table
  import ptts_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int AW        = 4
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data
);

  entry_t mem [MAX_TASKS];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: rtl/periodic_task_table_scheduler.sv
// Channel  Direction  Handshake              Payload
// in_      slave      in_tvalid / in_tready  tuser: command; tdata: task_id, amount
// out_     master     out_tvalid / out_tready tuser: fired; tdata: result fields; tlast
// cfg_     APB slave  psel, penable, pready  capacity register at byte address 0
//
// One item is worked on at a time; in_tready is high only while the sequencer is idle.
// A tick reads and checks each table entry; an entry with a nonzero interval then takes
// the 15-step remainder in the shared divider, an entry that fires takes a fire step,
// and the tick is set up before the scan and closed after it.
// A start or restart reads and checks entries until it finds the id, and a removal
// then moves each later entry down by one slot with a read and a write.
// Reset (rst_n low, synchronous) empties the table, zeroes the counter, sets capacity 16.
// A stalled out_tready holds the sequencer at the point where it must emit a result.
`default_nettype none
module periodic_task_table_scheduler
  import ptts_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tuser: command[1:0]
  input  wire logic [1:0]  in_tuser,
  // in_tdata: task_id[7:0], amount[23:8]
  input  wire logic [23:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tuser: fired[0]
  output logic [0:0]       out_tuser,
  // out_tdata: fired_id[7:0], fired_interval[22:8], status[23],
  // became_nonempty[24], became_empty[25], zeros above
  output logic [31:0]      out_tdata,
  output logic             out_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int AW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW   = $clog2(MAX_TASKS + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TPREP = 4'd1;
  localparam logic [3:0] S_TRD   = 4'd2;
  localparam logic [3:0] S_TCHK  = 4'd3;
  localparam logic [3:0] S_TDIV  = 4'd4;
  localparam logic [3:0] S_TFIRE = 4'd5;
  localparam logic [3:0] S_TEND  = 4'd6;
  localparam logic [3:0] S_FRD   = 4'd7;
  localparam logic [3:0] S_FCHK  = 4'd8;
  localparam logic [3:0] S_NEW   = 4'd9;
  localparam logic [3:0] S_RRD   = 4'd10;
  localparam logic [3:0] S_RWR   = 4'd11;
  localparam logic [3:0] S_RES   = 4'd12;

  logic [3:0]         state_r, state_nxt;
  logic [1:0]         cmd_r, cmd_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [15:0]        amt_r, amt_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CTR_W-1:0]   ctr_r, ctr_nxt;
  logic [CTR_W-1:0]   next_r, next_nxt;
  logic [CTR_W-1:0]   hi_r, hi_nxt;
  logic [CTR_W-1:0]   diff_r, diff_nxt;
  logic [CAP_W-1:0]   cap_r, cap_nxt;
  logic [NFIRE_W-1:0] nfire_r, nfire_nxt;
  logic               pend_v_r, pend_v_nxt;
  entry_t             pend_r, pend_nxt;
  entry_t             cur_r, cur_nxt;
  logic               rs_status_r, rs_status_nxt;
  logic               rs_ne_r, rs_ne_nxt;
  logic               rs_em_r, rs_em_nxt;
  logic               out_v_r, out_v_nxt;
  res_t               out_r, out_nxt;

  logic               out_free;
  logic               in_xfer;
  logic [CW-1:0]      idx_inc;
  logic               full;
  logic [CMPW-1:0]    cap_ext, max_ext, usable;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  entry_t             wr_data;
  logic [AW-1:0]      rd_addr;
  entry_t             rd_data;
  div_req_t           div_req;
  logic               div_done;
  logic [CTR_W-1:0]   div_rem;

  ptts_table #(
    .MAX_TASKS (MAX_TASKS),
    .AW        (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ptts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .rem   (div_rem)
  );

  assign out_free  = !out_v_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign idx_inc   = idx_r + 1'b1;
  assign cap_ext   = CMPW'(cap_r);
  assign max_ext   = CMPW'(MAX_TASKS);
  assign usable    = (cap_ext > max_ext) ? max_ext : cap_ext;
  assign full      = CMPW'(count_r) >= usable;

  always_comb begin
    unique case (state_r)
      S_RRD:   rd_addr = idx_inc[AW-1:0];
      default: rd_addr = idx_r[AW-1:0];
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    amt_nxt       = amt_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    ctr_nxt       = ctr_r;
    next_nxt      = next_r;
    hi_nxt        = hi_r;
    diff_nxt      = diff_r;
    nfire_nxt     = nfire_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    cur_nxt       = cur_r;
    rs_status_nxt = rs_status_r;
    rs_ne_nxt     = rs_ne_r;
    rs_em_nxt     = rs_em_r;
    out_nxt       = out_r;
    out_v_nxt     = out_tready ? 1'b0 : out_v_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r[AW-1:0];
    wr_data       = '{id: id_r, ivl: amt_r[CTR_W-1:0]};
    div_req       = '{start: 1'b0, dividend: hi_r, divisor: cur_r.ivl};

    unique case (state_r)
      S_IDLE: begin
        idx_nxt       = '0;
        nfire_nxt     = '0;
        pend_v_nxt    = 1'b0;
        rs_status_nxt = 1'b0;
        rs_ne_nxt     = 1'b0;
        rs_em_nxt     = 1'b0;
        if (in_xfer) begin
          cmd_nxt  = in_tuser;
          id_nxt   = in_tdata[7:0];
          amt_nxt  = in_tdata[23:8];
          next_nxt = ctr_r + in_tdata[8 +: CTR_W];
          if (in_tuser == CMD_TICK) begin
            state_nxt = S_TPREP;
          end else if ((in_tuser != CMD_START && in_tuser != CMD_RESTART)
                       || in_tdata[7:0] == '0) begin
            rs_status_nxt = 1'b1;
            state_nxt     = S_RES;
          end else if (count_r == '0) begin
            state_nxt = S_NEW;
          end else begin
            state_nxt = S_FRD;
          end
        end
      end

      // A task fires when a multiple of its interval lies in (lo, hi],
      // that is when hi mod interval is below hi - lo.
      S_TPREP: begin
        hi_nxt    = (next_r > ctr_r) ? next_r : ctr_r;
        diff_nxt  = (next_r > ctr_r) ? next_r - ctr_r : ctr_r - next_r;
        state_nxt = (count_r == '0) ? S_TEND : S_TRD;
      end

      S_TRD: begin
        state_nxt = S_TCHK;
      end

      S_TCHK: begin
        cur_nxt = rd_data;
        if (rd_data.ivl == '0) begin
          if (idx_inc == count_r) begin
            state_nxt = S_TEND;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_TRD;
          end
        end else begin
          div_req   = '{start: 1'b1, dividend: hi_r, divisor: rd_data.ivl};
          state_nxt = S_TDIV;
        end
      end

      S_TDIV: begin
        if (div_done) begin
          if (div_rem < diff_r) begin
            state_nxt = S_TFIRE;
          end else if (idx_inc == count_r) begin
            state_nxt = S_TEND;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_TRD;
          end
        end
      end

      // The previous due task is held back until it is known whether it is the last.
      S_TFIRE: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_v_nxt = 1'b1;
            out_nxt   = '{last: 1'b0, empty: 1'b0, nonempty: 1'b0, status: 1'b0,
                          ivl: pend_r.ivl, id: pend_r.id, fired: 1'b1};
          end
          pend_nxt   = cur_r;
          pend_v_nxt = 1'b1;
          nfire_nxt  = nfire_r + 1'b1;
          if (nfire_r == NFIRE_W'(RESULT_LIMIT - 1) || idx_inc == count_r) begin
            state_nxt = S_TEND;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_TRD;
          end
        end
      end

      S_TEND: begin
        if (out_free) begin
          out_v_nxt  = 1'b1;
          out_nxt    = '{last: 1'b1, empty: 1'b0, nonempty: 1'b0, status: 1'b0,
                         ivl: pend_v_r ? pend_r.ivl : '0,
                         id: pend_v_r ? pend_r.id : '0,
                         fired: pend_v_r};
          pend_v_nxt = 1'b0;
          ctr_nxt    = next_r;
          state_nxt  = S_IDLE;
        end
      end

      S_FRD: begin
        state_nxt = S_FCHK;
      end

      S_FCHK: begin
        if (rd_data.id == id_r) begin
          if (amt_r[15]) begin
            state_nxt = S_RRD;
          end else begin
            wr_en     = 1'b1;
            state_nxt = S_RES;
          end
        end else if (idx_inc == count_r) begin
          state_nxt = S_NEW;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_FRD;
        end
      end

      S_NEW: begin
        if (cmd_r == CMD_RESTART || amt_r[15] || full) begin
          rs_status_nxt = 1'b1;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = count_r[AW-1:0];
          count_nxt = count_r + 1'b1;
          rs_ne_nxt = (count_r == '0);
        end
        state_nxt = S_RES;
      end

      // Removal closes the gap by moving each later entry down one slot with a read and a write, keeping table order.
      S_RRD: begin
        if (idx_inc < count_r) begin
          state_nxt = S_RWR;
        end else begin
          count_nxt = count_r - 1'b1;
          rs_em_nxt = (count_r == CW'(1));
          state_nxt = S_RES;
        end
      end

      S_RWR: begin
        wr_en     = 1'b1;
        wr_data   = rd_data;
        idx_nxt   = idx_inc;
        state_nxt = S_RRD;
      end

      S_RES: begin
        if (out_free) begin
          out_v_nxt = 1'b1;
          out_nxt   = '{last: 1'b1, empty: rs_em_r, nonempty: rs_ne_r,
                        status: rs_status_r, ivl: '0, id: '0, fired: 1'b0};
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cap_nxt = cap_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
        && cfg_paddr[2] == REG_CAPACITY) begin
      cap_nxt = cfg_pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ctr_r    <= '0;
      cap_r    <= CAP_RESET;
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
      nfire_r  <= '0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ctr_r    <= ctr_nxt;
      cap_r    <= cap_nxt;
      out_v_r  <= out_v_nxt;
      pend_v_r <= pend_v_nxt;
      nfire_r  <= nfire_nxt;
      idx_r    <= idx_nxt;
    end
    cmd_r       <= cmd_nxt;
    id_r        <= id_nxt;
    amt_r       <= amt_nxt;
    next_r      <= next_nxt;
    hi_r        <= hi_nxt;
    diff_r      <= diff_nxt;
    pend_r      <= pend_nxt;
    cur_r       <= cur_nxt;
    rs_status_r <= rs_status_nxt;
    rs_ne_r     <= rs_ne_nxt;
    rs_em_r     <= rs_em_nxt;
    out_r       <= out_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_r.last;
  assign out_tuser  = out_r.fired;
  assign out_tdata  = {6'd0, out_r.empty, out_r.nonempty, out_r.status, out_r.ivl, out_r.id};

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_CAPACITY) ? {27'd0, cap_r} : 32'd0;

endmodule
`default_nettype wire

FILE: tb/tb_periodic_task_table_scheduler.sv
`timescale 1ns / 1ps
module tb_periodic_task_table_scheduler;
  import ptts_pkg::*;

  localparam int TASK_SLOTS  = 16;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 400;

  // A command code the scheduler does not define.
  localparam logic [1:0] CMD_UNDEFINED = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  tid;
    logic [15:0] amt;
  } job_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic [1:0]  in_tuser    = '0;
  logic [23:0] in_tdata    = '0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [0:0]  out_tuser;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Shadow of the scheduler state.
  logic [ID_W-1:0]  tbl_ids  [TASK_SLOTS];
  logic [CTR_W-1:0] tbl_ivls [TASK_SLOTS];
  int               tbl_count = 0;
  logic [CTR_W-1:0] clock_now = '0;
  logic [CAP_W-1:0] cap_now   = CAP_RESET;

  job_t pending_jobs[$];
  res_t awaited_reports[$];
  job_t on_bus;
  bit   gaps_on = 1'b1;
  int   err_count = 0;
  int   quiet_cycles = 0;

  periodic_task_table_scheduler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #4 clk = ~clk;

  task automatic note_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    err_count++;
  endtask

  // Works out the reports one accepted command causes and updates the shadow state.
  task automatic forecast_reports(input job_t j);
    res_t             r;
    res_t             held;
    bit               have;
    logic [CTR_W-1:0] nxt;
    logic [CTR_W-1:0] d;
    int               n;
    int               pos;
    int               usable;
    r    = '0;
    held = '0;
    have = 1'b0;
    n    = 0;
    if (j.cmd == CMD_TICK) begin
      nxt = clock_now + j.amt[CTR_W-1:0];
      for (int i = 0; i < tbl_count; i++) begin
        d = tbl_ivls[i];
        if (d != '0 && (clock_now / d) != (nxt / d) && n < RESULT_LIMIT) begin
          if (have) awaited_reports.push_back(held);
          held       = '0;
          held.fired = 1'b1;
          held.id    = tbl_ids[i];
          held.ivl   = d;
          have       = 1'b1;
          n++;
        end
      end
      clock_now = nxt;
      if (have) begin
        held.last = 1'b1;
        awaited_reports.push_back(held);
      end else begin
        r.last = 1'b1;
        awaited_reports.push_back(r);
      end
    end else begin
      r.last = 1'b1;
      if ((j.cmd != CMD_START && j.cmd != CMD_RESTART) || j.tid == '0) begin
        r.status = 1'b1;
      end else begin
        pos = tbl_count;
        for (int i = tbl_count - 1; i >= 0; i--) begin
          if (tbl_ids[i] == j.tid) pos = i;
        end
        usable = (cap_now > TASK_SLOTS) ? TASK_SLOTS : int'(cap_now);
        if (pos == tbl_count) begin
          if (j.cmd == CMD_RESTART || j.amt[15] || tbl_count >= usable) begin
            r.status = 1'b1;
          end else begin
            tbl_ids[tbl_count]  = j.tid;
            tbl_ivls[tbl_count] = j.amt[CTR_W-1:0];
            tbl_count++;
            r.nonempty = (tbl_count == 1);
          end
        end else if (j.amt[15]) begin
          // Removal closes the gap so that the firing order is kept.
          for (int i = pos; i < tbl_count - 1; i++) begin
            tbl_ids[i]  = tbl_ids[i + 1];
            tbl_ivls[i] = tbl_ivls[i + 1];
          end
          tbl_count--;
          r.empty = (tbl_count == 0);
        end else begin
          tbl_ivls[pos] = j.amt[CTR_W-1:0];
        end
      end
      awaited_reports.push_back(r);
    end
  endtask

  // Command driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) forecast_reports(on_bus);
      if (!in_tvalid || in_tready) begin
        if (pending_jobs.size() != 0 && !(gaps_on && $urandom_range(99) < 13)) begin
          on_bus = pending_jobs.pop_front();
          in_tuser  <= on_bus.cmd;
          in_tdata  <= {on_bus.amt, on_bus.tid};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Report monitor.
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_reports.size() == 0) begin
          note_mismatch("unexpected report, tdata", out_tdata, 0);
        end else begin
          want = awaited_reports.pop_front();
          if (out_tuser[0] !== want.fired) note_mismatch("fired", out_tuser[0], want.fired);
          if (out_tdata[7:0] !== want.id) note_mismatch("fired_id", out_tdata[7:0], want.id);
          if (out_tdata[22:8] !== want.ivl)
            note_mismatch("fired_interval", out_tdata[22:8], want.ivl);
          if (out_tdata[23] !== want.status) note_mismatch("status", out_tdata[23], want.status);
          if (out_tdata[24] !== want.nonempty)
            note_mismatch("became_nonempty", out_tdata[24], want.nonempty);
          if (out_tdata[25] !== want.empty)
            note_mismatch("became_empty", out_tdata[25], want.empty);
          if (out_tdata[31:26] !== '0) note_mismatch("tdata padding", out_tdata[31:26], 0);
          if (out_tlast !== want.last) note_mismatch("tlast", out_tlast, want.last);
        end
      end
      out_tready <= !(gaps_on && $urandom_range(99) < 13);
    end
  end

  // Ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_periodic_task_table_scheduler failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_job(input logic [1:0] cmd, input logic [7:0] tid, input logic [15:0] amt);
    job_t j;
    j.cmd = cmd;
    j.tid = tid;
    j.amt = amt;
    pending_jobs.push_back(j);
  endtask

  function automatic logic [7:0] pick_id();
    if ($urandom_range(99) < 90) return 8'($urandom_range(1, 20));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] pick_interval(input int removal_pct);
    int k;
    k = $urandom_range(99);
    if (k < removal_pct) return {1'b1, 15'($urandom)};
    if (k < removal_pct + 8) return 16'd0;
    if (k < 85) return 16'($urandom_range(1, 60));
    return {1'b0, 15'($urandom)};
  endfunction

  // Mostly ticks and well-formed start/restart traffic on a small id pool.
  task automatic queue_random(input int count);
    int k;
    int a;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      if (k < 40) begin
        a = $urandom_range(99);
        if (a < 50) queue_job(CMD_TICK, 8'($urandom), 16'($urandom_range(0, 40)));
        else if (a < 75) queue_job(CMD_TICK, 8'($urandom), 16'($urandom_range(0, 2000)));
        else queue_job(CMD_TICK, 8'($urandom), 16'($urandom));
      end else if (k < 70) begin
        queue_job(CMD_START, pick_id(), pick_interval(12));
      end else if (k < 92) begin
        queue_job(CMD_RESTART, pick_id(), pick_interval(15));
      end else if (k < 96) begin
        queue_job($urandom_range(0, 1) ? CMD_START : CMD_RESTART, 8'd0, 16'($urandom));
      end else begin
        queue_job(CMD_UNDEFINED, 8'($urandom), 16'($urandom));
      end
    end
  endtask

  // Waits until every command has been taken, every report has arrived and the
  // sequencer is back to idle. Sampling at the falling edge sees the driver's
  // updates of the rising edge already settled.
  task automatic settle();
    while (pending_jobs.size() != 0 || in_tvalid || awaited_reports.size() != 0)
      @(negedge clk);
    while (!in_tready) @(negedge clk);
  endtask

  // Writes the capacity register and reads it back.
  task automatic write_capacity(input logic [CAP_W-1:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(4 * REG_CAPACITY);
    cfg_pwdata  <= 32'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cap_now     = val;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== 32'(val)) note_mismatch("capacity readback", cfg_prdata, val);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table, rejected commands, then a small table ticked through wraparound.
    queue_job(CMD_TICK, 8'd0, 16'd0);
    queue_job(CMD_START, 8'd0, 16'd5);
    queue_job(CMD_RESTART, 8'd0, 16'd5);
    queue_job(CMD_UNDEFINED, 8'd9, 16'd5);
    queue_job(CMD_RESTART, 8'd5, 16'd5);
    queue_job(CMD_START, 8'd7, 16'hFFFF);
    queue_job(CMD_START, 8'd1, 16'd10);
    queue_job(CMD_START, 8'd255, 16'h7FFF);
    queue_job(CMD_START, 8'd128, 16'd0);
    queue_job(CMD_START, 8'd2, 16'd1);
    queue_job(CMD_TICK, 8'd0, 16'd25);
    queue_job(CMD_RESTART, 8'd1, 16'd10);
    queue_job(CMD_START, 8'd2, 16'd3);
    queue_job(CMD_TICK, 8'hFF, 16'h7FFF);
    queue_job(CMD_TICK, 8'd0, 16'h8000);
    queue_job(CMD_TICK, 8'd0, 16'hFFFF);
    queue_job(CMD_TICK, 8'd0, 16'd32744);
    queue_job(CMD_RESTART, 8'd2, 16'hFFFF);
    queue_job(CMD_START, 8'd1, 16'h8000);
    queue_job(CMD_START, 8'd255, 16'hFFFF);
    queue_job(CMD_RESTART, 8'd128, 16'hFFFB);
    queue_job(CMD_TICK, 8'd0, 16'd100);
    settle();

    write_capacity(5'd1);
    queue_job(CMD_START, 8'd3, 16'd5);
    queue_job(CMD_START, 8'd4, 16'd5);
    queue_job(CMD_START, 8'd3, 16'hFFFA);
    settle();

    write_capacity(5'd0);
    queue_job(CMD_START, 8'd9, 16'd4);
    queue_job(CMD_TICK, 8'd0, 16'd9);
    settle();

    // Capacity above the table size saturates; fill the table and fire all entries.
    write_capacity(5'd31);
    for (int i = 1; i <= TASK_SLOTS + 1; i++)
      queue_job(CMD_START, 8'(i), 16'($urandom_range(1, 60)));
    queue_job(CMD_TICK, 8'd0, 16'd2000);
    gaps_on = 1'b0;
    queue_random(90);
    settle();
    gaps_on = 1'b1;

    // Capacity below the current count, with the sender holding off halfway.
    write_capacity(5'd4);
    queue_random(50);
    settle();
    queue_random(50);
    settle();

    write_capacity(5'd16);
    queue_random(45);
    settle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_reports.size() != 0)
      note_mismatch("reports never received", awaited_reports.size(), 0);
    if (err_count == 0) begin
      $display("tb_periodic_task_table_scheduler passed");
    end else begin
      $display("tb_periodic_task_table_scheduler failed");
    end
    $finish;
  end

endmodule
